// ===== src/vgrt_pkg.sv =====
// Package for the voxel grid ray traversal block.
// Holds the grid and fixed-point constants, the sequencer state type and face codes; no dependencies.
`timescale 1ns / 1ps
package vgrt_pkg;
    // grid edge in voxels and fraction bits of the fixed-point fields
    localparam int GRID_SIZE = 16;
    localparam int FRAC_BITS = 16;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SETUP, ST_DIV, ST_DIVNEXT, ST_CHK0, ST_CHK0W,
        ST_STEP, ST_CHK, ST_CHKW, ST_OUT
    } state_t;

    localparam logic [2:0] FACE_NONE   = 3'd0;
    localparam logic [2:0] FACE_WEST   = 3'd1;
    localparam logic [2:0] FACE_EAST   = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_TOP    = 3'd4;
    localparam logic [2:0] FACE_NORTH  = 3'd5;
    localparam logic [2:0] FACE_SOUTH  = 3'd6;
endpackage

// ===== src/vgrt_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
`timescale 1ns / 1ps
module vgrt_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== src/vgrt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`timescale 1ns / 1ps
module vgrt_div #(
    parameter int NW = 48,
    parameter int DW = 17
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;

    assign trial = {r_reg[DW-1:0], q_reg[NW-1]};
    assign quo   = q_reg;
    assign done  = busy_reg && (cnt_reg == CW'(0));

    // shift in one numerator bit, subtract when it fits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
            q_reg    <= num;
            r_reg    <= '0;
            d_reg    <= den;
        end else if (busy_reg) begin
            if (cnt_reg == CW'(0)) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - CW'(1);
                if (trial >= {1'b0, d_reg}) begin
                    r_reg <= trial - {1'b0, d_reg};
                    q_reg <= {q_reg[NW-2:0], 1'b1};
                end else begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NW-2:0], 1'b0};
                end
            end
        end
    end
endmodule

// ===== src/voxel_grid_ray_traversal.sv =====
// Top level of the voxel grid ray traversal block.
// Uses vgrt_pkg, vgrt_div and vgrt_ram.
//
//  channel | direction | payload
//  s_      | in        | op, voxel xyz, solid, origin, dir, reach
//  m_      | out       | hit, cell xyz, face, distance
//
// A write passes through the output state to the result register. A cast
// runs six serial divisions on the shared divider (skipped when that direction
// component is zero), an origin check, then for each voxel step a step, an
// occupancy read and a check, and then the output state. Reset clears the occupancy
// map, during which no transaction is accepted. A result waits in its register until
// taken; the next transaction may start meanwhile but holds in its output state.
`timescale 1ns / 1ps
module voxel_grid_ray_traversal (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [3:0]         s_voxel_x,
    input  logic [3:0]         s_voxel_y,
    input  logic [3:0]         s_voxel_z,
    input  logic               s_solid,
    input  logic signed [24:0] s_origin_x,
    input  logic signed [24:0] s_origin_y,
    input  logic signed [24:0] s_origin_z,
    input  logic signed [17:0] s_dir_x,
    input  logic signed [17:0] s_dir_y,
    input  logic signed [17:0] s_dir_z,
    input  logic [22:0]        s_reach,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic [3:0]         m_cell_x,
    output logic [3:0]         m_cell_y,
    output logic [3:0]         m_cell_z,
    output logic [2:0]         m_face,
    output logic [22:0]        m_distance
);
    localparam int GRID_SIZE = vgrt_pkg::GRID_SIZE;
    localparam int FRAC_BITS = vgrt_pkg::FRAC_BITS;
    localparam int GB    = $clog2(GRID_SIZE);
    localparam int AW    = 3 * GB;
    localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int NW    = 2 * FRAC_BITS + 2;
    localparam int TW    = NW + 2;
    localparam int CLW   = 26 - FRAC_BITS + 2;
    localparam logic [TW-1:0] TINF = '1;

    vgrt_pkg::state_t state_reg, state_next;

    logic [AW:0]   clr_reg;
    logic          clearing;
    logic signed [24:0] org_reg [3];
    logic signed [17:0] dir_reg [3];
    logic [22:0]   reach_reg;
    logic signed [CLW-1:0] cell_reg [3];
    logic [TW-1:0] tmax_reg [3];
    logic [TW-1:0] tdel_reg [3];
    logic [2:0]    div_idx_reg;
    logic [2:0]    face_reg;
    logic [TW-1:0] t_reg;
    logic          res_hit_reg;
    logic [3:0]    res_c_reg [3];
    logic [2:0]    res_face_reg;
    logic [22:0]   res_dist_reg;
    logic          mvalid_reg;
    logic          res_load;

    // per-axis setup terms
    logic signed [CLW-1:0] fl [3];
    logic [FRAC_BITS-1:0]  frc [3];
    logic [17:0]           mag [3];
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            fl[a]  = CLW'(org_reg[a] >>> FRAC_BITS);
            frc[a] = org_reg[a][FRAC_BITS-1:0];
            mag[a] = dir_reg[a][17] ? 18'(-dir_reg[a]) : 18'(dir_reg[a]);
        end
    end

    // divider operand selection: even index first boundary, odd per-cell
    logic          div_start;
    logic [NW-1:0] div_num;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [1:0]    ax;
    logic [FRAC_BITS:0] bnd_dist;
    assign ax = div_idx_reg[2:1];
    always_comb begin
        if (dir_reg[ax][17]) bnd_dist = {1'b0, frc[ax]};
        else                 bnd_dist = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, frc[ax]};
        if (div_idx_reg[0]) div_num = NW'(1) << (2 * FRAC_BITS);
        else                div_num = NW'(bnd_dist) << FRAC_BITS;
    end

    vgrt_div #(.NW(NW), .DW(18)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_num), .den(mag[ax]), .done(div_done), .quo(div_quo)
    );

    // occupancy map
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic          ram_wdata, ram_rdata;
    logic          wr_in;
    logic          inmap;

    assign wr_in = ({1'b0, s_voxel_x} < 5'(GRID_SIZE)) && ({1'b0, s_voxel_y} < 5'(GRID_SIZE))
                 && ({1'b0, s_voxel_z} < 5'(GRID_SIZE));
    assign clearing = !clr_reg[AW];
    assign s_ready  = !clearing && (state_reg == vgrt_pkg::ST_IDLE);
    assign ram_we    = clearing || (s_valid && s_ready && !s_op && wr_in);
    assign ram_waddr = clearing ? clr_reg[AW-1:0]
                     : {s_voxel_z[GB-1:0], s_voxel_y[GB-1:0], s_voxel_x[GB-1:0]};
    assign ram_wdata = clearing ? 1'b0 : s_solid;
    assign ram_raddr = {cell_reg[2][GB-1:0], cell_reg[1][GB-1:0], cell_reg[0][GB-1:0]};

    always_comb begin
        inmap = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (cell_reg[a] < 0 || cell_reg[a] >= CLW'(GRID_SIZE)) inmap = 1'b0;
        end
    end

    vgrt_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_occ (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // axis choice: X only when strictly smallest, Y only when below Z; ties go to the later axis
    logic [1:0] sel;
    always_comb begin
        if (tmax_reg[0] < tmax_reg[1] && tmax_reg[0] < tmax_reg[2]) sel = 2'd0;
        else if (tmax_reg[1] < tmax_reg[2])                          sel = 2'd1;
        else                                                          sel = 2'd2;
    end
    logic inmap_q;

    // load the result register once it is free or being taken
    assign res_load = (state_reg == vgrt_pkg::ST_OUT) && (!mvalid_reg || m_ready);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            vgrt_pkg::ST_IDLE:
                if (s_valid && s_ready) state_next = s_op ? vgrt_pkg::ST_SETUP : vgrt_pkg::ST_OUT;
            vgrt_pkg::ST_SETUP:
                if (dir_reg[ax] == '0) state_next = vgrt_pkg::ST_DIVNEXT;
                else begin
                    div_start  = 1'b1;
                    state_next = vgrt_pkg::ST_DIV;
                end
            vgrt_pkg::ST_DIV:
                if (div_done) state_next = vgrt_pkg::ST_DIVNEXT;
            vgrt_pkg::ST_DIVNEXT:
                state_next = (div_idx_reg == 3'd5) ? vgrt_pkg::ST_CHK0 : vgrt_pkg::ST_SETUP;
            vgrt_pkg::ST_CHK0:  state_next = vgrt_pkg::ST_CHK0W;
            vgrt_pkg::ST_CHK0W:
                state_next = (inmap_q && ram_rdata) ? vgrt_pkg::ST_OUT : vgrt_pkg::ST_STEP;
            vgrt_pkg::ST_STEP:
                state_next = (tmax_reg[sel] > TW'(reach_reg)) ? vgrt_pkg::ST_OUT
                                                               : vgrt_pkg::ST_CHK;
            vgrt_pkg::ST_CHK:   state_next = vgrt_pkg::ST_CHKW;
            vgrt_pkg::ST_CHKW:
                state_next = (inmap_q && ram_rdata) ? vgrt_pkg::ST_OUT : vgrt_pkg::ST_STEP;
            vgrt_pkg::ST_OUT:
                if (res_load) state_next = vgrt_pkg::ST_IDLE;
            default:            state_next = vgrt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= vgrt_pkg::ST_IDLE;
        else          state_reg <= state_next;
    end

    // clear sweep after reset
    always_ff @(posedge aclk) begin
        if (!aresetn)      clr_reg <= '0;
        else if (clearing) clr_reg <= clr_reg + (AW+1)'(1);
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        inmap_q <= inmap;
        case (state_reg)
            vgrt_pkg::ST_IDLE:
                if (s_valid && s_ready) begin
                    org_reg[0] <= s_origin_x; org_reg[1] <= s_origin_y;
                    org_reg[2] <= s_origin_z;
                    dir_reg[0] <= s_dir_x; dir_reg[1] <= s_dir_y; dir_reg[2] <= s_dir_z;
                    reach_reg   <= s_reach;
                    div_idx_reg <= '0;
                    res_hit_reg <= 1'b0;
                    face_reg    <= vgrt_pkg::FACE_NONE;
                    t_reg       <= '0;
                end
            vgrt_pkg::ST_SETUP:
                if (dir_reg[ax] == '0) begin
                    if (div_idx_reg[0]) tdel_reg[ax] <= TINF;
                    else                tmax_reg[ax] <= TINF;
                end
            vgrt_pkg::ST_DIV:
                if (div_done) begin
                    if (div_idx_reg[0]) tdel_reg[ax] <= (div_quo == '0) ? TW'(1) : TW'(div_quo);
                    else                tmax_reg[ax] <= TW'(div_quo);
                end
            vgrt_pkg::ST_DIVNEXT: begin
                div_idx_reg <= div_idx_reg + 3'd1;
                for (int a = 0; a < 3; a++) cell_reg[a] <= fl[a];
            end
            vgrt_pkg::ST_CHK0W:
                if (inmap_q && ram_rdata) res_hit_reg <= 1'b1;
            vgrt_pkg::ST_STEP: begin
                t_reg <= tmax_reg[sel];
                if (tmax_reg[sel] != TINF) tmax_reg[sel] <= tmax_reg[sel] + tdel_reg[sel];
                cell_reg[sel] <= dir_reg[sel] > 0 ? cell_reg[sel] + CLW'(1)
                                                  : cell_reg[sel] - CLW'(1);
                unique case (sel)
                    2'd0:    face_reg <= dir_reg[0] > 0 ? vgrt_pkg::FACE_WEST
                                                        : vgrt_pkg::FACE_EAST;
                    2'd1:    face_reg <= dir_reg[1] > 0 ? vgrt_pkg::FACE_BOTTOM
                                                        : vgrt_pkg::FACE_TOP;
                    default: face_reg <= dir_reg[2] > 0 ? vgrt_pkg::FACE_NORTH
                                                        : vgrt_pkg::FACE_SOUTH;
                endcase
            end
            vgrt_pkg::ST_CHKW:
                if (inmap_q && ram_rdata) res_hit_reg <= 1'b1;
            default: ;
        endcase
    end

    // result register, held until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) mvalid_reg <= 1'b0;
        else if (res_load) mvalid_reg <= 1'b1;
        else if (m_ready) mvalid_reg <= 1'b0;
        if (res_load) begin
            for (int a = 0; a < 3; a++)
                res_c_reg[a] <= res_hit_reg ? 4'(cell_reg[a]) : 4'd0;
            res_face_reg <= res_hit_reg ? face_reg : vgrt_pkg::FACE_NONE;
            res_dist_reg <= res_hit_reg ? t_reg[22:0] : 23'd0;
        end
    end
    logic out_hit_reg;
    always_ff @(posedge aclk) begin
        if (res_load) out_hit_reg <= res_hit_reg;
    end

    assign m_valid    = mvalid_reg;
    assign m_hit      = out_hit_reg;
    assign m_cell_x   = res_c_reg[0];
    assign m_cell_y   = res_c_reg[1];
    assign m_cell_z   = res_c_reg[2];
    assign m_face     = res_face_reg;
    assign m_distance = res_dist_reg;

`ifndef ASSERT_OFF
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready) else $error("accept during clear");
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == vgrt_pkg::ST_IDLE) else $error("ready while busy");
    a_out_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == vgrt_pkg::ST_OUT |=> m_valid) else $error("result lost");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_face == vgrt_pkg::FACE_NONE && m_distance == '0))
        else $error("miss with payload");
`endif
endmodule

// ===== tb/voxel_grid_ray_traversal_test.sv =====
// Testbench for voxel_grid_ray_traversal: directed table, then random writes and casts.
// Checks each result against its table value or an in-bench DDA walk; depends on vgrt_pkg and the RTL.
`timescale 1ns / 1ps
module voxel_grid_ray_traversal_test;

    localparam int          CYCLE_LIMIT = 4000000;
    localparam int          RANDOM_ITEMS = 600;
    localparam longint      ONE_Q = 64'sd65536;
    localparam int          MAX_REACH = 4194304;
    localparam longint unsigned T_NEVER = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam bit          OP_WRITE = 1'b0;
    localparam bit          OP_CAST = 1'b1;

    typedef struct {
        bit                op;
        logic [3:0]        vx, vy, vz;
        bit                solid;
        logic signed [24:0] ox, oy, oz;
        logic signed [17:0] dx, dy, dz;
        logic [22:0]       reach;
    } request_t;

    typedef struct {
        bit          hit;
        logic [3:0]  cx, cy, cz;
        logic [2:0]  face;
        logic [22:0] distance;
    } hit_report_t;

    typedef struct {
        request_t    req;
        bit          typed;
        hit_report_t want;
    } table_row_t;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid, s_ready, s_op, s_solid;
    logic [3:0]         s_voxel_x, s_voxel_y, s_voxel_z;
    logic signed [24:0] s_origin_x, s_origin_y, s_origin_z;
    logic signed [17:0] s_dir_x, s_dir_y, s_dir_z;
    logic [22:0]        s_reach;
    logic               m_valid, m_ready, m_hit;
    logic [3:0]         m_cell_x, m_cell_y, m_cell_z;
    logic [2:0]         m_face;
    logic [22:0]        m_distance;

    bit          occ_map [4096];
    hit_report_t pending_results[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 35;
    int          recv_idle_pct = 54;

    voxel_grid_ray_traversal dut (.*);

    always #4 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("** voxel_grid_ray_traversal: FAILED **");
            $finish;
        end
    end

    task automatic note_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void axis_init(input longint o, input longint d,
                                      output longint cidx, output int stp,
                                      output longint unsigned tnext,
                                      output longint unsigned tcell);
        longint frac;
        longint unsigned mag, num;
        cidx = o >>> 16;
        frac = o - cidx * ONE_Q;
        stp = (d > 0) ? 1 : -1;
        if (d == 0) begin
            tnext = T_NEVER;
            tcell = T_NEVER;
            return;
        end
        mag = (d > 0) ? d : -d;
        num = (d > 0) ? (ONE_Q - frac) : frac;
        tnext = (num << 16) / mag;
        tcell = (64'd1 << 32) / mag;
        if (tcell == 0) tcell = 1;
    endfunction

    function automatic bit occupied(input longint x, input longint y, input longint z);
        if (x < 0 || y < 0 || z < 0 || x > 15 || y > 15 || z > 15) return 1'b0;
        return occ_map[x + 16 * (y + 16 * z)];
    endfunction

    // Apply one transaction to the map copy and walk the ray
    function automatic hit_report_t cast_ray(input request_t r);
        hit_report_t res;
        longint cx, cy, cz;
        int sx, sy, sz;
        longint unsigned mx, my, mz, ex, ey, ez, t;
        logic [2:0] f;
        res = '{default: 0};
        if (r.op == OP_WRITE) begin
            occ_map[r.vx + 16 * (r.vy + 16 * r.vz)] = r.solid;
            return res;
        end
        axis_init(longint'(r.ox), longint'(r.dx), cx, sx, mx, ex);
        axis_init(longint'(r.oy), longint'(r.dy), cy, sy, my, ey);
        axis_init(longint'(r.oz), longint'(r.dz), cz, sz, mz, ez);
        if (occupied(cx, cy, cz)) begin
            res.hit = 1'b1;
            res.cx = cx[3:0]; res.cy = cy[3:0]; res.cz = cz[3:0];
            res.face = vgrt_pkg::FACE_NONE;
            return res;
        end
        forever begin
            if (mx < my && mx < mz) begin
                cx += sx; t = mx;
                if (mx != T_NEVER) mx += ex;
                f = (sx > 0) ? vgrt_pkg::FACE_WEST : vgrt_pkg::FACE_EAST;
            end else if (my < mz) begin
                cy += sy; t = my;
                if (my != T_NEVER) my += ey;
                f = (sy > 0) ? vgrt_pkg::FACE_BOTTOM : vgrt_pkg::FACE_TOP;
            end else begin
                cz += sz; t = mz;
                if (mz != T_NEVER) mz += ez;
                f = (sz > 0) ? vgrt_pkg::FACE_NORTH : vgrt_pkg::FACE_SOUTH;
            end
            if (t > r.reach) return res;
            if (occupied(cx, cy, cz)) begin
                res.hit = 1'b1;
                res.cx = cx[3:0]; res.cy = cy[3:0]; res.cz = cz[3:0];
                res.face = f;
                res.distance = t[22:0];
                return res;
            end
        end
    endfunction

    // Present one transaction, hold until taken, then record what it should yield
    task automatic send_request(input request_t r, input bit typed, input hit_report_t want);
        hit_report_t got;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= r.op;
        s_voxel_x <= r.vx; s_voxel_y <= r.vy; s_voxel_z <= r.vz;
        s_solid <= r.solid;
        s_origin_x <= r.ox; s_origin_y <= r.oy; s_origin_z <= r.oz;
        s_dir_x <= r.dx; s_dir_y <= r.dy; s_dir_z <= r.dz;
        s_reach <= r.reach;
        do @(posedge aclk); while (!s_ready);
        got = cast_ray(r);
        pending_results.push_back(typed ? want : got);
    endtask

    // Take results and compare against the oldest prediction
    always @(posedge aclk) begin
        hit_report_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("result with nothing outstanding");
                end else begin
                    w = pending_results.pop_front();
                    if (m_hit !== w.hit || m_cell_x !== w.cx || m_cell_y !== w.cy ||
                        m_cell_z !== w.cz || m_face !== w.face || m_distance !== w.distance)
                        note_mismatch($sformatf(
                            "got hit %0d cell %0d,%0d,%0d face %0d dist %0d, want %0d %0d,%0d,%0d %0d %0d",
                            m_hit, m_cell_x, m_cell_y, m_cell_z, m_face, m_distance,
                            w.hit, w.cx, w.cy, w.cz, w.face, w.distance));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic request_t write_req(input int x, input int y, input int z, input bit s);
        request_t r;
        r = '{default: 0};
        r.op = OP_WRITE; r.vx = 4'(x); r.vy = 4'(y); r.vz = 4'(z); r.solid = s;
        return r;
    endfunction

    function automatic request_t cast_req(input int ox, input int oy, input int oz,
                                          input int dx, input int dy, input int dz,
                                          input int reach);
        request_t r;
        r = '{default: 0};
        r.op = OP_CAST;
        r.ox = 25'(ox); r.oy = 25'(oy); r.oz = 25'(oz);
        r.dx = 18'(dx); r.dy = 18'(dy); r.dz = 18'(dz);
        r.reach = 23'(reach);
        return r;
    endfunction

    function automatic table_row_t row(input request_t r, input bit typed,
                                       input hit_report_t want = '{default: 0});
        table_row_t tr;
        tr.req = r; tr.typed = typed; tr.want = want;
        return tr;
    endfunction

    // Random transaction: mostly casts through or near the grid
    function automatic request_t random_req();
        request_t r;
        r.op = 1'($urandom_range(1)); r.solid = 1'($urandom_range(1));
        r.vx = 4'($urandom); r.vy = 4'($urandom); r.vz = 4'($urandom);
        r.ox = 25'($urandom); r.oy = 25'($urandom); r.oz = 25'($urandom);
        r.dx = 18'($urandom); r.dy = 18'($urandom); r.dz = 18'($urandom);
        r.reach = 23'($urandom_range(MAX_REACH));
        if ($urandom_range(99) < 35) begin
            r.op = OP_WRITE;
            r.solid = ($urandom_range(99) < 75);
        end else begin
            r.op = OP_CAST;
            if ($urandom_range(99) < 85) begin
                r.ox = 25'(int'($urandom_range(20 * 65536)) - 2 * 65536);
                r.oy = 25'(int'($urandom_range(20 * 65536)) - 2 * 65536);
                r.oz = 25'(int'($urandom_range(20 * 65536)) - 2 * 65536);
            end
            if ($urandom_range(9) == 0) r.dx = '0;
            if ($urandom_range(9) == 0) r.dy = '0;
            if ($urandom_range(9) == 0) r.dz = '0;
        end
        return r;
    endfunction

    table_row_t directed[$];
    hit_report_t miss;
    hit_report_t in_solid;

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0; s_op = 1'b0; s_solid = 1'b0;
        s_voxel_x = '0; s_voxel_y = '0; s_voxel_z = '0;
        s_origin_x = '0; s_origin_y = '0; s_origin_z = '0;
        s_dir_x = '0; s_dir_y = '0; s_dir_z = '0;
        s_reach = '0;
        foreach (occ_map[i]) occ_map[i] = 1'b0;
        miss = '{default: 0};
        in_solid = '{hit: 1'b1, cx: 4'd0, cy: 4'd0, cz: 4'd0, face: vgrt_pkg::FACE_NONE,
                     distance: 23'd0};

        // Directed table: empty map, zero direction, inside solid, every face, extremes
        directed.push_back(row(cast_req(8 << 16, 8 << 16, 8 << 16, 65536, 0, 0, MAX_REACH),
                               1'b1, miss));
        directed.push_back(row(cast_req(3 << 16, 3 << 16, 3 << 16, 0, 0, 0, MAX_REACH),
                               1'b1, miss));
        directed.push_back(row(write_req(0, 0, 0, 1'b1), 1'b1, miss));
        directed.push_back(row(cast_req(32768, 32768, 32768, 65536, 65536, 65536, 0),
                               1'b1, in_solid));
        directed.push_back(row(write_req(15, 15, 15, 1'b1), 1'b1, miss));
        directed.push_back(row(write_req(5, 8, 8, 1'b1), 1'b1, miss));
        directed.push_back(row(write_req(11, 8, 8, 1'b1), 1'b1, miss));
        directed.push_back(row(write_req(8, 5, 8, 1'b1), 1'b1, miss));
        directed.push_back(row(write_req(8, 11, 8, 1'b1), 1'b1, miss));
        directed.push_back(row(write_req(8, 8, 5, 1'b1), 1'b1, miss));
        directed.push_back(row(write_req(8, 8, 11, 1'b1), 1'b1, miss));
        directed.push_back(row(cast_req(557056, 557056, 557056, -65536, 0, 0, MAX_REACH), 0));
        directed.push_back(row(cast_req(557056, 557056, 557056, 65536, 0, 0, MAX_REACH), 0));
        directed.push_back(row(cast_req(557056, 557056, 557056, 0, -65536, 0, MAX_REACH), 0));
        directed.push_back(row(cast_req(557056, 557056, 557056, 0, 131071, 0, MAX_REACH), 0));
        directed.push_back(row(cast_req(557056, 557056, 557056, 0, 0, -131072, MAX_REACH), 0));
        directed.push_back(row(cast_req(557056, 557056, 557056, 1, 1, 40000, MAX_REACH), 0));
        // equal boundary times on all axes
        directed.push_back(row(cast_req(4 << 16, 4 << 16, 4 << 16, 65536, 65536, 65536,
                                        MAX_REACH), 0));
        directed.push_back(row(cast_req(-16777216, 16777215, -16777216, 131071, -131072, 1,
                                        MAX_REACH), 0));
        directed.push_back(row(cast_req(16777215, -16777216, 16777215, -131072, 131071, -1,
                                        MAX_REACH), 0));
        directed.push_back(row(cast_req(-65536, -65536, -65536, 65536, 65536, 65536,
                                        MAX_REACH), 0));
        directed.push_back(row(write_req(15, 15, 15, 1'b0), 1'b1, miss));
        directed.push_back(row(write_req(0, 0, 0, 1'b0), 1'b1, miss));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].want);

        // Random traffic over three idling regimes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 54 : 0;
            recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 35 : 0;
            for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
                send_request(random_req(), 1'b0, miss);
                // hold off once per phase until no result is outstanding
                if (n == RANDOM_ITEMS / 6) begin
                    s_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge aclk);
                end
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0)
            $display("** voxel_grid_ray_traversal: PASSED **");
        else
            $display("** voxel_grid_ray_traversal: FAILED **");
        $finish;
    end
endmodule

// ===== voxel_grid_ray_traversal.f =====
src/vgrt_pkg.sv
src/vgrt_ram.sv
src/vgrt_div.sv
src/voxel_grid_ray_traversal.sv
tb/voxel_grid_ray_traversal_test.sv
